@@ hdl/qea_pkg.sv @@
// qea_pkg: shared constants, types and helpers for the quadric error accumulator.
// Saturating 64-bit arithmetic, plane and evaluation term tables, width helpers.
// No dependencies.
package qea_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  // coefficient slots
  localparam int Q_COUNT = 10;
  localparam int IDX_W   = $clog2(Q_COUNT + 1);
  localparam logic [IDX_W-1:0] Q_A2 = IDX_W'(0);
  localparam logic [IDX_W-1:0] Q_B2 = IDX_W'(1);
  localparam logic [IDX_W-1:0] Q_C2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] Q_D2 = IDX_W'(3);
  localparam logic [IDX_W-1:0] Q_AB = IDX_W'(4);
  localparam logic [IDX_W-1:0] Q_AC = IDX_W'(5);
  localparam logic [IDX_W-1:0] Q_AD = IDX_W'(6);
  localparam logic [IDX_W-1:0] Q_BC = IDX_W'(7);
  localparam logic [IDX_W-1:0] Q_BD = IDX_W'(8);
  localparam logic [IDX_W-1:0] Q_CD = IDX_W'(9);

  // coordinate selects for evaluation terms
  localparam logic [1:0] SEL_X   = 2'd0;
  localparam logic [1:0] SEL_Y   = 2'd1;
  localparam logic [1:0] SEL_Z   = 2'd2;
  localparam logic [1:0] SEL_ONE = 2'd3;

  // plane component selects
  localparam logic [1:0] PL_A = 2'd0;
  localparam logic [1:0] PL_B = 2'd1;
  localparam logic [1:0] PL_C = 2'd2;
  localparam logic [1:0] PL_D = 2'd3;

  localparam int WIDE_W = 80;

  typedef struct packed {
    logic [IDX_W-1:0] coef_idx;
    logic             dbl;
    logic [1:0]       u_sel;
    logic [1:0]       v_sel;
  } term_t;

  typedef struct packed {
    logic [1:0] lhs;
    logic [1:0] rhs;
  } pair_t;

  // derived widths
  function automatic int cross_w(input int cb);
    return 2 * (cb + 1) + 1;
  endfunction

  function automatic int plane_w(input int cb);
    return cross_w(cb) + cb + 2;
  endfunction

  function automatic int entry_w(input int cb);
    return 2 + 3 * cross_w(cb) + plane_w(cb) + 3 * cb;
  endfunction

  // clamp a wide signed value to signed 64 bits
  function automatic logic signed [63:0] sat64(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (&v[WIDE_W-1:63]) | ~(|v[WIDE_W-1:63]);
    if (fits) begin
      sat64 = v[63:0];
    end else if (v[WIDE_W-1]) begin
      sat64 = {1'b1, 63'd0};
    end else begin
      sat64 = {1'b0, {63{1'b1}}};
    end
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  // evaluation terms, summed in this order
  function automatic term_t term_info(input logic [IDX_W-1:0] k);
    term_t t;
    case (k)
      IDX_W'(0): t = '{Q_A2, 1'b0, SEL_X,   SEL_X};
      IDX_W'(1): t = '{Q_AB, 1'b1, SEL_X,   SEL_Y};
      IDX_W'(2): t = '{Q_AC, 1'b1, SEL_X,   SEL_Z};
      IDX_W'(3): t = '{Q_AD, 1'b1, SEL_X,   SEL_ONE};
      IDX_W'(4): t = '{Q_B2, 1'b0, SEL_Y,   SEL_Y};
      IDX_W'(5): t = '{Q_BC, 1'b1, SEL_Y,   SEL_Z};
      IDX_W'(6): t = '{Q_BD, 1'b1, SEL_Y,   SEL_ONE};
      IDX_W'(7): t = '{Q_C2, 1'b0, SEL_Z,   SEL_Z};
      IDX_W'(8): t = '{Q_CD, 1'b1, SEL_Z,   SEL_ONE};
      default:   t = '{Q_D2, 1'b0, SEL_ONE, SEL_ONE};
    endcase
    return t;
  endfunction

  // plane product operands, indexed by coefficient slot
  function automatic pair_t pair_info(input logic [IDX_W-1:0] k);
    pair_t p;
    case (k)
      Q_A2:    p = '{PL_A, PL_A};
      Q_B2:    p = '{PL_B, PL_B};
      Q_C2:    p = '{PL_C, PL_C};
      Q_D2:    p = '{PL_D, PL_D};
      Q_AB:    p = '{PL_A, PL_B};
      Q_AC:    p = '{PL_A, PL_C};
      Q_AD:    p = '{PL_A, PL_D};
      Q_BC:    p = '{PL_B, PL_C};
      Q_BD:    p = '{PL_B, PL_D};
      default: p = '{PL_C, PL_D};
    endcase
    return p;
  endfunction

endpackage

@@ hdl/quadric_error_accumulator_core.sv @@
// quadric_error_accumulator_core: top level of the quadric error accumulator.
// Depends on qea_pkg, qea_front, qea_fifo and qea_back.
//
// Keeps one running quadric of ten signed 64-bit coefficients (a2, b2, c2, d2,
// ab, ac, ad, bc, bd, cd). Each input word carries a command and three corners.
// Clear zeroes the quadric. Add forms the unnormalized plane normal
// n = (B-A) x (C-A) and offset d = -(n . A), then adds the ten plane products
// to the quadric with saturation at signed 64 bits. Evaluate uses corner A as
// the query point and returns the quadric error there, saturated and clamped
// at zero, with out_is_evaluation set; every other command returns one word
// with a zero error. Exactly one result word per input word, in order.
// Timing: the front end is a two-stage pipeline (cross product, then offset)
// taking one word per cycle, while the queue has room, into a two-entry queue.
// The back end executes one command at a time: clear or an unused code goes
// straight to the result, add steps through the ten plane products, one per
// cycle through a single multiplier with accumulate overlapped, and evaluate
// steps through ten terms, three steps each, through one 64 x COORD_BITS
// saturating multiplier and a saturating adder. The back-end sequencer sets the sustained rate. A result held by
// out_stall does not block the back end from starting the next command.
module quadric_error_accumulator_core #(
  parameter int COORD_BITS = qea_pkg::COORD_BITS_DEF   // 4 to 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic signed [COORD_BITS-1:0] in_corner_a_x,
  input  logic signed [COORD_BITS-1:0] in_corner_a_y,
  input  logic signed [COORD_BITS-1:0] in_corner_a_z,
  input  logic signed [COORD_BITS-1:0] in_corner_b_x,
  input  logic signed [COORD_BITS-1:0] in_corner_b_y,
  input  logic signed [COORD_BITS-1:0] in_corner_b_z,
  input  logic signed [COORD_BITS-1:0] in_corner_c_x,
  input  logic signed [COORD_BITS-1:0] in_corner_c_y,
  input  logic signed [COORD_BITS-1:0] in_corner_c_z,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [62:0]                  out_error_value,
  output logic                         out_is_evaluation
);
  import qea_pkg::*;

  localparam int EW = entry_w(COORD_BITS);

  // front -> queue
  logic          q_push, q_full;
  logic [EW-1:0] q_push_data;
  // queue -> back
  logic          q_pop, q_empty;
  logic [EW-1:0] q_pop_data;

  // plane setup: differences, cross product, offset
  qea_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_corner_a_x (in_corner_a_x),
    .in_corner_a_y (in_corner_a_y),
    .in_corner_a_z (in_corner_a_z),
    .in_corner_b_x (in_corner_b_x),
    .in_corner_b_y (in_corner_b_y),
    .in_corner_b_z (in_corner_b_z),
    .in_corner_c_x (in_corner_c_x),
    .in_corner_c_y (in_corner_c_y),
    .in_corner_c_z (in_corner_c_z),
    .push          (q_push),
    .full          (q_full),
    .push_data     (q_push_data)
  );

  // decoupling queue: front keeps accepting while back is busy
  qea_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // quadric store, accumulate and evaluate sequencer, output register
  qea_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (q_empty),
    .pop               (q_pop),
    .pop_data          (q_pop_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_error_value   (out_error_value),
    .out_is_evaluation (out_is_evaluation)
  );

endmodule

@@ hdl/qea_front.sv @@
// qea_front: accepts input words and forms the plane (a, b, c, d) in two stages.
// Depends on qea_pkg; feeds qea_fifo.
module qea_front #(
  parameter int COORD_BITS = qea_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [1:0]                                    in_command,
  input  logic signed [COORD_BITS-1:0]                  in_corner_a_x,
  input  logic signed [COORD_BITS-1:0]                  in_corner_a_y,
  input  logic signed [COORD_BITS-1:0]                  in_corner_a_z,
  input  logic signed [COORD_BITS-1:0]                  in_corner_b_x,
  input  logic signed [COORD_BITS-1:0]                  in_corner_b_y,
  input  logic signed [COORD_BITS-1:0]                  in_corner_b_z,
  input  logic signed [COORD_BITS-1:0]                  in_corner_c_x,
  input  logic signed [COORD_BITS-1:0]                  in_corner_c_y,
  input  logic signed [COORD_BITS-1:0]                  in_corner_c_z,
  output logic                                          push,
  input  logic                                          full,
  output logic [qea_pkg::entry_w(COORD_BITS)-1:0]       push_data
);
  import qea_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int CW = cross_w(CB);
  localparam int PW = plane_w(CB);

  // stage 1: edge vectors and cross product
  logic signed [DW-1:0]   ux, uy, uz, vx, vy, vz;
  logic signed [2*DW-1:0] m_a0, m_a1, m_b0, m_b1, m_c0, m_c1;
  logic signed [CW-1:0]   a_val, b_val, c_val;

  assign ux = DW'(in_corner_b_x) - DW'(in_corner_a_x);
  assign uy = DW'(in_corner_b_y) - DW'(in_corner_a_y);
  assign uz = DW'(in_corner_b_z) - DW'(in_corner_a_z);
  assign vx = DW'(in_corner_c_x) - DW'(in_corner_a_x);
  assign vy = DW'(in_corner_c_y) - DW'(in_corner_a_y);
  assign vz = DW'(in_corner_c_z) - DW'(in_corner_a_z);

  assign m_a0 = uy * vz;
  assign m_a1 = uz * vy;
  assign m_b0 = uz * vx;
  assign m_b1 = ux * vz;
  assign m_c0 = ux * vy;
  assign m_c1 = uy * vx;

  assign a_val = CW'(m_a0) - CW'(m_a1);
  assign b_val = CW'(m_b0) - CW'(m_b1);
  assign c_val = CW'(m_c0) - CW'(m_c1);

  logic                 s1_v_r;
  logic [1:0]           s1_cmd_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r, s1_c_r;
  logic signed [CB-1:0] s1_x_r, s1_y_r, s1_z_r;

  // stage 2: offset d = -(n . A)
  logic signed [CW+CB-1:0] p_x, p_y, p_z;
  logic signed [PW-1:0]    dot_sum, d_val;

  assign p_x     = s1_a_r * s1_x_r;
  assign p_y     = s1_b_r * s1_y_r;
  assign p_z     = s1_c_r * s1_z_r;
  assign dot_sum = PW'(p_x) + PW'(p_y) + PW'(p_z);
  assign d_val   = -dot_sum;

  logic                 s2_v_r;
  logic [1:0]           s2_cmd_r;
  logic signed [CW-1:0] s2_a_r, s2_b_r, s2_c_r;
  logic signed [PW-1:0] s2_d_r;
  logic signed [CB-1:0] s2_x_r, s2_y_r, s2_z_r;

  logic s2_free, s1_go, s1_free, in_accept;

  assign s2_free   = !s2_v_r || !full;
  assign s1_go     = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s2_free;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;
  assign push      = s2_v_r && !full;
  assign push_data = {s2_cmd_r, s2_a_r, s2_b_r, s2_c_r, s2_d_r, s2_x_r, s2_y_r, s2_z_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_accept;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r <= in_command;
      s1_a_r   <= a_val;
      s1_b_r   <= b_val;
      s1_c_r   <= c_val;
      s1_x_r   <= in_corner_a_x;
      s1_y_r   <= in_corner_a_y;
      s1_z_r   <= in_corner_a_z;
    end
    if (s1_go) begin
      s2_cmd_r <= s1_cmd_r;
      s2_a_r   <= s1_a_r;
      s2_b_r   <= s1_b_r;
      s2_c_r   <= s1_c_r;
      s2_d_r   <= d_val;
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_y_r;
      s2_z_r   <= s1_z_r;
    end
  end

endmodule

@@ hdl/qea_fifo.sv @@
// qea_fifo: short register queue between front and back.
// Depends on qea_pkg for the default depth.
module qea_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = qea_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import qea_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/qea_back.sv @@
// qea_back: executes queued commands against the stored quadric and drives results.
// Depends on qea_pkg; takes entries from qea_fifo.
module qea_back #(
  parameter int COORD_BITS = qea_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    empty,
  output logic                                    pop,
  input  logic [qea_pkg::entry_w(COORD_BITS)-1:0] pop_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [62:0]                             out_error_value,
  output logic                                    out_is_evaluation
);
  import qea_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = cross_w(CB);
  localparam int PW = plane_w(CB);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [1:0] PH_U   = 2'd0;
  localparam logic [1:0] PH_V   = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  // unpack queue entry
  logic [1:0]           e_cmd;
  logic signed [CW-1:0] e_a, e_b, e_c;
  logic signed [PW-1:0] e_d;
  logic signed [CB-1:0] e_x, e_y, e_z;

  assign {e_cmd, e_a, e_b, e_c, e_d, e_x, e_y, e_z} = pop_data;

  logic [1:0]           state_r, state_nxt;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [CB-1:0] px_r, py_r, pz_r;
  logic [IDX_W-1:0]     step_r;
  logic [1:0]           phase_r;
  logic signed [63:0]   prod_r, t_r, sum_r;
  logic                 res_eval_r;
  logic signed [63:0]   coef_r [Q_COUNT];

  logic out_valid_r;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_IDLE) && !empty;

  // plane product path
  pair_t                pair;
  logic signed [PW-1:0] op_l, op_r;
  logic signed [2*PW-1:0] plane_prod;

  function automatic logic signed [PW-1:0] plane_pick(input logic [1:0] sel,
      input logic signed [PW-1:0] a, input logic signed [PW-1:0] b,
      input logic signed [PW-1:0] c, input logic signed [PW-1:0] d);
    logic signed [PW-1:0] r;
    case (sel)
      PL_A:    r = a;
      PL_B:    r = b;
      PL_C:    r = c;
      default: r = d;
    endcase
    return r;
  endfunction

  assign pair       = pair_info(step_r);
  assign op_l       = plane_pick(pair.lhs, pa_r, pb_r, pc_r, pd_r);
  assign op_r       = plane_pick(pair.rhs, pa_r, pb_r, pc_r, pd_r);
  assign plane_prod = op_l * op_r;

  // evaluation path
  term_t                term;
  logic [IDX_W-1:0]     acc_idx, rd_idx;
  logic signed [63:0]   coef_rd, dbl_val, ev_lhs;
  logic signed [CB-1:0] ev_rhs;
  logic signed [63+CB:0] ev_prod;

  function automatic logic signed [CB-1:0] coord_pick(input logic [1:0] sel,
      input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
      input logic signed [CB-1:0] z);
    logic signed [CB-1:0] r;
    case (sel)
      SEL_X:   r = x;
      SEL_Y:   r = y;
      SEL_Z:   r = z;
      default: r = CB'(1);
    endcase
    return r;
  endfunction

  assign term    = term_info(step_r);
  assign acc_idx = step_r - IDX_W'(1);
  assign rd_idx  = (state_r == ST_ADD) ? acc_idx : term.coef_idx;
  assign coef_rd = coef_r[rd_idx];
  assign dbl_val = term.dbl ? sat_add64(coef_rd, coef_rd) : coef_rd;
  assign ev_lhs  = (phase_r == PH_U) ? dbl_val : t_r;
  assign ev_rhs  = coord_pick((phase_r == PH_U) ? term.u_sel : term.v_sel,
                              px_r, py_r, pz_r);
  assign ev_prod = ev_lhs * ev_rhs;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          case (e_cmd)
            CMD_ADD:  state_nxt = ST_ADD;
            CMD_EVAL: state_nxt = ST_EVAL;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD: begin
        if (step_r == IDX_W'(Q_COUNT)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_EVAL: begin
        if (phase_r == PH_SUM && step_r == IDX_W'(Q_COUNT - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < Q_COUNT; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop && e_cmd == CMD_CLEAR) begin
        for (int i = 0; i < Q_COUNT; i++) begin
          coef_r[i] <= '0;
        end
      end
      if (state_r == ST_ADD && step_r != '0) begin
        coef_r[acc_idx] <= sat_add64(coef_rd, prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pa_r       <= PW'(e_a);
      pb_r       <= PW'(e_b);
      pc_r       <= PW'(e_c);
      pd_r       <= e_d;
      px_r       <= e_x;
      py_r       <= e_y;
      pz_r       <= e_z;
      step_r     <= '0;
      phase_r    <= PH_U;
      sum_r      <= '0;
      res_eval_r <= (e_cmd == CMD_EVAL);
    end
    case (state_r)
      ST_ADD: begin
        if (step_r != IDX_W'(Q_COUNT)) begin
          prod_r <= sat64(WIDE_W'(plane_prod));
          step_r <= step_r + IDX_W'(1);
        end
      end
      ST_EVAL: begin
        case (phase_r)
          PH_U: begin
            t_r     <= sat64(WIDE_W'(ev_prod));
            phase_r <= PH_V;
          end
          PH_V: begin
            t_r     <= sat64(WIDE_W'(ev_prod));
            phase_r <= PH_SUM;
          end
          default: begin
            sum_r   <= sat_add64(sum_r, t_r);
            phase_r <= PH_U;
            step_r  <= step_r + IDX_W'(1);
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_is_evaluation <= res_eval_r;
          out_error_value   <= (res_eval_r && !sum_r[63] && (|sum_r)) ? sum_r[62:0] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
